/* hdl/wmmb_pkg.sv */
// Shared constants and types for the min/max waveform pyramid builder.
package wmmb_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int MAX_LEVELS   = 8;
  localparam int RATIO        = 4;
  localparam int SAMPLE_BITS  = 24;

  localparam int CH_W     = 3;
  localparam int LVL_W    = 3;
  localparam int NCH_W    = 4;
  localparam int NLEV_W   = 4;
  localparam int BASE_W   = 16;
  localparam int PIDX_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W    = $clog2(RATIO + 1);

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE,
    REG_CHANNELS,
    REG_LEVELS
  } reg_idx_e;

  // Per-item control broadcast from the top level to every level cell.
  typedef struct packed {
    logic              start;
    logic              adv;
    logic [CH_W-1:0]   ch;
    logic              last_ch;
    logic              flush;
    logic              close0;
    logic [NLEV_W-1:0] nlev;
  } ctrl_t;

  // Min/max word handed from one level cell to the next.
  typedef struct packed {
    logic                          vld;
    logic signed [SAMPLE_BITS-1:0] min;
    logic signed [SAMPLE_BITS-1:0] max;
  } tok_t;

  typedef struct packed {
    logic                          vld;
    logic                          last;
    logic [LVL_W-1:0]              level;
    logic [CH_W-1:0]               ch;
    logic [PIDX_W-1:0]             pidx;
    logic signed [SAMPLE_BITS-1:0] min;
    logic signed [SAMPLE_BITS-1:0] max;
  } res_t;

endpackage

/* hdl/waveform_minmax_mip_builder_top.sv */
// Top level of the min/max waveform pyramid builder.
// Interleaved audio samples enter one word at a time on the input channel
// (in_valid_i, in_stall_o); the block tracks channel and frame position itself.
// Closed peaks leave on the output channel (out_valid_o, out_stall_i), tagged
// with level, channel and peak index; last_result_o marks an item's final peak.
// A row of level cells holds the running min/max per channel; a closing peak
// is handed from one cell to the next, one level per cycle unless the
// receiver stalls. An accepted sample is registered in level zero, and each
// peak it closes passes through the output register, the lowest level first.
// The next sample is taken once the cascade of the previous one has ended.
// When the receiver stalls, the cascade holds in place and the output word
// stays put. Registers are written on the configuration channel while idle
// and while no sample is offered.
// Reset restores 256 frames per peak, 2 channels and 8 levels, and empties
// every running min/max and peak counter.
module waveform_minmax_mip_builder_top import wmmb_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_frame_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [LVL_W-1:0]              level_index_o,
  output logic [CH_W-1:0]               channel_index_o,
  output logic [PIDX_W-1:0]             peak_index_o,
  output logic signed [SAMPLE_BITS-1:0] peak_min_o,
  output logic signed [SAMPLE_BITS-1:0] peak_max_o,
  output logic                          last_result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [BASE_W-1:0]             cfg_data_i
);

  logic [BASE_W-1:0] base_q;
  logic [NCH_W-1:0]  nch_q;
  logic [NLEV_W-1:0] nlev_q;
  logic [BASE_W-1:0] base_eff;
  logic [NCH_W-1:0]  nch_eff;
  logic [NLEV_W-1:0] nlev_eff;

  logic [CH_W-1:0]   ch_cnt_q;
  logic [BASE_W-1:0] frame_q;
  logic [CH_W-1:0]   ch_q;
  logic              last_ch_q;
  logic              flush_q;
  logic              close0_q;
  logic              start_q;

  logic              accept;
  logic              last_ch_now;
  logic              close0_now;
  logic              adv;
  logic              busy;
  ctrl_t             ctrl;

  tok_t              tok_chain [MAX_LEVELS+1];
  logic [CNT_W-1:0]  cnt_vec   [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] busy_vec;
  res_t              res_vec   [MAX_LEVELS];
  res_t              res_any;

  logic              out_valid_q;
  res_t              out_res_q;

  always_comb begin
    base_eff = (base_q == '0) ? BASE_W'(1) : base_q;
    if (nch_q == '0) begin
      nch_eff = NCH_W'(1);
    end else if (nch_q > NCH_W'(MAX_CHANNELS)) begin
      nch_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      nch_eff = nch_q;
    end
    if (nlev_q == '0) begin
      nlev_eff = NLEV_W'(1);
    end else if (nlev_q > NLEV_W'(MAX_LEVELS)) begin
      nlev_eff = NLEV_W'(MAX_LEVELS);
    end else begin
      nlev_eff = nlev_q;
    end
  end

  assign busy        = |busy_vec;
  assign in_stall_o  = busy;
  // A register write never lands on the edge that takes a sample.
  assign cfg_ready_o = !busy && !in_valid_i;
  assign accept      = in_valid_i && !busy;
  assign adv         = !out_valid_q || !out_stall_i;

  assign last_ch_now = ({1'b0, ch_cnt_q} + NCH_W'(1)) >= nch_eff;
  assign close0_now  = last_frame_i ||
                       (({1'b0, frame_q} + (BASE_W+1)'(1)) >= {1'b0, base_eff});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_W'(256);
      nch_q    <= NCH_W'(2);
      nlev_q   <= NLEV_W'(8);
      ch_cnt_q <= '0;
      frame_q  <= '0;
      start_q  <= 1'b0;
    end else begin
      start_q <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BASE:     base_q <= cfg_data_i;
          REG_CHANNELS: nch_q  <= cfg_data_i[NCH_W-1:0];
          REG_LEVELS:   nlev_q <= cfg_data_i[NLEV_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (last_ch_now) begin
          ch_cnt_q <= '0;
          frame_q  <= close0_now ? '0 : frame_q + 1'b1;
        end else begin
          ch_cnt_q <= ch_cnt_q + 1'b1;
        end
      end
    end
  end

  // Item context, held for the whole cascade.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q      <= '0;
      last_ch_q <= 1'b0;
      flush_q   <= 1'b0;
      close0_q  <= 1'b0;
    end else if (accept) begin
      ch_q      <= ch_cnt_q;
      last_ch_q <= last_ch_now;
      flush_q   <= last_frame_i;
      close0_q  <= close0_now;
    end
  end

  always_comb begin
    ctrl.start   = start_q;
    ctrl.adv     = adv;
    ctrl.ch      = ch_q;
    ctrl.last_ch = last_ch_q;
    ctrl.flush   = flush_q;
    ctrl.close0  = close0_q;
    ctrl.nlev    = nlev_eff;
  end

  // The sample enters level zero as a degenerate min/max pair.
  always_comb begin
    tok_chain[0].vld = accept;
    tok_chain[0].min = sample_i;
    tok_chain[0].max = sample_i;
  end

  for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_lvl
    logic [CNT_W-1:0] nb_cnt;
    if (l == MAX_LEVELS - 1) begin : g_top
      assign nb_cnt = '0;
    end else begin : g_mid
      assign nb_cnt = cnt_vec[l+1];
    end

    wmmb_cell #(
      .LEVEL(l)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .tok_i    (tok_chain[l]),
      .nb_cnt_i (nb_cnt),
      .tok_o    (tok_chain[l+1]),
      .cnt_o    (cnt_vec[l]),
      .busy_o   (busy_vec[l]),
      .res_o    (res_vec[l])
    );
  end

  // At most one cell holds the word, so the results merge by OR.
  always_comb begin
    res_any = '0;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      res_any = res_any | res_vec[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_any.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_any.vld) begin
      out_res_q <= res_any;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_index_o   = out_res_q.level;
  assign channel_index_o = out_res_q.ch;
  assign peak_index_o    = out_res_q.pidx;
  assign peak_min_o      = out_res_q.min;
  assign peak_max_o      = out_res_q.max;
  assign last_result_o   = out_res_q.last;

  a_one_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(busy_vec))
    else $error("more than one level cell holds a word");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_vec[0])
    else $error("accepted sample did not reach level zero");

  a_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_any.vld && !res_any.last) |=> busy)
    else $error("cascade ended after a result not marked last");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tok_chain[MAX_LEVELS].vld)
    else $error("top level cell passed a word upward");

endmodule

/* hdl/wmmb_cell.sv */
// One pyramid level: running min/max and merge counts for every channel.
module wmmb_cell import wmmb_pkg::*; #(
  parameter int LEVEL = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  input  tok_t             tok_i,
  input  logic [CNT_W-1:0] nb_cnt_i,
  output tok_t             tok_o,
  output logic [CNT_W-1:0] cnt_o,
  output logic             busy_o,
  output res_t             res_o
);

  localparam logic IS_BASE = (LEVEL == 0);
  localparam logic [LVL_W-1:0] LVL = LVL_W'(LEVEL);
  localparam logic [NLEV_W-1:0] NEXT = NLEV_W'(LEVEL + 1);
  localparam logic [CNT_W-1:0] RATIO_C = CNT_W'(RATIO);

  logic signed [SAMPLE_BITS-1:0] min_q [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] max_q [MAX_CHANNELS];
  logic [CNT_W-1:0]              cnt_q [MAX_CHANNELS];
  logic [PIDX_W-1:0]             pidx_q;
  logic                          tok_vld_q;
  logic signed [SAMPLE_BITS-1:0] tok_min_q;
  logic signed [SAMPLE_BITS-1:0] tok_max_q;

  logic signed [SAMPLE_BITS-1:0] rd_min;
  logic signed [SAMPLE_BITS-1:0] rd_max;
  logic [CNT_W-1:0]              rd_cnt;
  logic signed [SAMPLE_BITS-1:0] m_min;
  logic signed [SAMPLE_BITS-1:0] m_max;
  logic [CNT_W-1:0]              cnt_n;
  logic                          close;
  logic                          fire;
  logic                          go_up;
  logic                          in_use;
  logic                          nb_close;

  always_comb begin
    rd_min = min_q[ctrl_i.ch];
    rd_max = max_q[ctrl_i.ch];
    rd_cnt = cnt_q[ctrl_i.ch];
    m_min  = (tok_min_q < rd_min) ? tok_min_q : rd_min;
    m_max  = (tok_max_q > rd_max) ? tok_max_q : rd_max;
    cnt_n  = IS_BASE ? rd_cnt : CNT_W'(rd_cnt + 1'b1);
    close  = IS_BASE ? ctrl_i.close0 : (ctrl_i.flush || (cnt_n >= RATIO_C));
    fire   = ctrl_i.adv && tok_vld_q;
    go_up  = NEXT < ctrl_i.nlev;
    in_use = NEXT <= ctrl_i.nlev;
    // The level above closes too if it is flushed or this merge fills it.
    nb_close = ctrl_i.flush || (CNT_W'(nb_cnt_i + 1'b1) >= RATIO_C);

    res_o = '0;
    if (fire && close) begin
      res_o.vld   = 1'b1;
      res_o.last  = !go_up || !nb_close;
      res_o.level = LVL;
      res_o.ch    = ctrl_i.ch;
      res_o.pidx  = pidx_q;
      res_o.min   = m_min;
      res_o.max   = m_max;
    end

    tok_o.vld = fire && close && go_up;
    tok_o.min = m_min;
    tok_o.max = m_max;
  end

  assign cnt_o  = rd_cnt;
  assign busy_o = tok_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      pidx_q    <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        min_q[c] <= SMAX;
        max_q[c] <= SMIN;
        cnt_q[c] <= '0;
      end
    end else begin
      if (tok_i.vld) begin
        tok_vld_q <= 1'b1;
      end else if (fire) begin
        tok_vld_q <= 1'b0;
      end
      if (fire) begin
        if (close) begin
          min_q[ctrl_i.ch] <= SMAX;
          max_q[ctrl_i.ch] <= SMIN;
          cnt_q[ctrl_i.ch] <= '0;
          if (ctrl_i.last_ch) begin
            pidx_q <= ctrl_i.flush ? '0 : pidx_q + 1'b1;
          end
        end else begin
          min_q[ctrl_i.ch] <= m_min;
          max_q[ctrl_i.ch] <= m_max;
          cnt_q[ctrl_i.ch] <= cnt_n;
        end
      end
      // Levels beyond the active count never emit, so a final frame clears their peak index here.
      if (ctrl_i.start && ctrl_i.flush && ctrl_i.last_ch && !in_use) begin
        pidx_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      tok_min_q <= tok_i.min;
      tok_max_q <= tok_i.max;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt < RATIO_C)
    else $error("merge count reached the ratio without closing");

  a_base_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !IS_BASE || (rd_cnt == '0))
    else $error("level zero holds a merge count");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vld_q && !fire) |=> tok_vld_q)
    else $error("a waiting word was dropped before it was processed");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the min/max waveform pyramid builder top level.
module tb;
  import wmmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0]              level;
    logic [CH_W-1:0]               chan;
    logic [PIDX_W-1:0]             pidx;
    logic signed [SAMPLE_BITS-1:0] pk_min;
    logic signed [SAMPLE_BITS-1:0] pk_max;
    logic                          last;
  } peak_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic                          last_frame_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [LVL_W-1:0]              level_index_o;
  logic [CH_W-1:0]               channel_index_o;
  logic [PIDX_W-1:0]             peak_index_o;
  logic signed [SAMPLE_BITS-1:0] peak_min_o;
  logic signed [SAMPLE_BITS-1:0] peak_max_o;
  logic                          last_result_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [BASE_W-1:0]             cfg_data_i;

  // Mirror of the block's registers and pyramid state.
  logic [BASE_W-1:0]             reg_base;
  logic [NCH_W-1:0]              reg_nch;
  logic [NLEV_W-1:0]             reg_nlev;
  int unsigned                   ch_pos;
  int unsigned                   frame_pos;
  logic signed [SAMPLE_BITS-1:0] trk_min [MAX_CHANNELS*MAX_LEVELS];
  logic signed [SAMPLE_BITS-1:0] trk_max [MAX_CHANNELS*MAX_LEVELS];
  int unsigned                   merges [MAX_CHANNELS*MAX_LEVELS];
  logic [PIDX_W-1:0]             level_count [MAX_LEVELS];

  peak_t expected_peaks[$];
  int    fail_count;
  int    items_sent;
  int    hold_cycles;
  bit    in_gaps;
  bit    out_gaps;

  waveform_minmax_mip_builder_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .last_frame_i   (last_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_index_o  (level_index_o),
    .channel_index_o(channel_index_o),
    .peak_index_o   (peak_index_o),
    .peak_min_o     (peak_min_o),
    .peak_max_o     (peak_max_o),
    .last_result_o  (last_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_pyramid();
    reg_base  = 16'd256;
    reg_nch   = 4'd2;
    reg_nlev  = 4'd8;
    ch_pos    = 0;
    frame_pos = 0;
    for (int i = 0; i < MAX_CHANNELS * MAX_LEVELS; i++) begin
      trk_min[i] = SMAX;
      trk_max[i] = SMIN;
      merges[i]  = 0;
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      level_count[i] = '0;
    end
  endfunction

  function automatic int unsigned eff_channels();
    if (reg_nch == 0) return 1;
    if (reg_nch > MAX_CHANNELS) return MAX_CHANNELS;
    return reg_nch;
  endfunction

  // Folds one sample into the pyramid and queues the peaks it closes.
  function automatic void predict_peaks(input logic signed [SAMPLE_BITS-1:0] s,
                                        input logic lf);
    int unsigned nch, nlev, ch, slot, up, lvl, blk;
    bit last_ch, close0, more;
    logic signed [SAMPLE_BITS-1:0] lo, hi;
    peak_t p;
    nch  = eff_channels();
    nlev = (reg_nlev == 0) ? 1 : ((reg_nlev > MAX_LEVELS) ? MAX_LEVELS : reg_nlev);
    blk  = (reg_base == 0) ? 1 : reg_base;
    ch = ch_pos;
    last_ch = (ch + 1 >= nch);
    slot = ch * MAX_LEVELS;
    if (s < trk_min[slot]) trk_min[slot] = s;
    if (s > trk_max[slot]) trk_max[slot] = s;
    close0 = lf || (frame_pos + 1 >= blk);
    if (close0) begin
      for (lvl = 0; lvl < nlev; lvl++) begin
        slot = ch * MAX_LEVELS + lvl;
        lo = trk_min[slot];
        hi = trk_max[slot];
        p.level  = LVL_W'(lvl);
        p.chan   = CH_W'(ch);
        p.pidx   = level_count[lvl];
        p.pk_min = lo;
        p.pk_max = hi;
        // All channels of one peak share its index, so only the last one advances it.
        if (last_ch) level_count[lvl]++;
        trk_min[slot] = SMAX;
        trk_max[slot] = SMIN;
        merges[slot]  = 0;
        more = 1'b0;
        if (lvl + 1 < nlev) begin
          up = slot + 1;
          if (lo < trk_min[up]) trk_min[up] = lo;
          if (hi > trk_max[up]) trk_max[up] = hi;
          merges[up]++;
          more = lf || (merges[up] >= RATIO);
        end
        p.last = !more;
        expected_peaks.push_back(p);
        if (!more) break;
      end
    end
    if (last_ch) begin
      ch_pos = 0;
      if (lf) begin
        frame_pos = 0;
        for (int i = 0; i < MAX_LEVELS; i++) level_count[i] = '0;
      end else if (close0) begin
        frame_pos = 0;
      end else begin
        frame_pos = (frame_pos + 1) & 32'hFFFF;
      end
    end else begin
      ch_pos = ch + 1;
    end
  endfunction

  // Watches all three channels at the rising edge: results first, then new words.
  always @(posedge clk_i) begin
    peak_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{level_index_o, channel_index_o, peak_index_o,
                peak_min_o, peak_max_o, last_result_o};
        if (expected_peaks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected peak: lvl=%0d ch=%0d idx=%0d min=%0d max=%0d last=%0b",
                     got.level, got.chan, got.pidx, got.pk_min, got.pk_max, got.last);
        end else begin
          want = expected_peaks.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("peak mismatch at %0t", $realtime);
              $display("  expected lvl=%0d ch=%0d idx=%0d min=%0d max=%0d last=%0b",
                       want.level, want.chan, want.pidx, want.pk_min, want.pk_max,
                       want.last);
              $display("  actual   lvl=%0d ch=%0d idx=%0d min=%0d max=%0d last=%0b",
                       got.level, got.chan, got.pidx, got.pk_min, got.pk_max, got.last);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) predict_peaks(sample_i, last_frame_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BASE:     reg_base = cfg_data_i;
          REG_CHANNELS: reg_nch  = cfg_data_i[NCH_W-1:0];
          REG_LEVELS:   reg_nlev = cfg_data_i[NLEV_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  // Output stall: random short bursts, plus a long hold-off when one is requested.
  initial begin
    int burst;
    burst = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 4);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return SMAX;
      1:       return SMIN;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic lf);
    @(negedge clk_i);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_i     <= s;
    last_frame_i <= lf;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk_i);
    // A word that closes no peak may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [BASE_W-1:0] base, input logic [BASE_W-1:0] nch,
                           input logic [BASE_W-1:0] nlev);
    wait_drained();
    put_reg(REG_BASE, base);
    put_reg(REG_CHANNELS, nch);
    put_reg(REG_LEVELS, nlev);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One buffer of interleaved frames; the final frame carries last_frame, and noisy buffers flip it at random.
  task automatic send_buffer(input int frames, input bit noisy);
    logic lf;
    for (int f = 0; f < frames; f++) begin
      for (int c = 0; c < eff_channels(); c++) begin
        lf = (f == frames - 1);
        if (noisy && $urandom_range(0, 24) == 0) lf = !lf;
        send_sample(rand_sample(), lf);
      end
    end
  endtask

  // Reset registers: a short buffer flushes every level of both channels.
  task automatic test_reset_values();
    send_sample(SMAX, 1'b0);
    send_sample(SMIN, 1'b0);
    send_sample('0, 1'b1);
    send_sample(-24'sd1, 1'b1);
  endtask

  // Zero and oversized register values are clamped; the unused index is ignored.
  task automatic test_register_limits();
    configure(16'd0, 16'd0, 16'd0);
    send_sample(24'sd5, 1'b0);
    send_sample(SMAX, 1'b0);
    send_sample(SMIN, 1'b1);
    configure(16'd1, 16'h000F, 16'h00FF);
    put_reg(REG_UNUSED, 16'hFFFF);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    send_sample(SMIN, 1'b1);
  endtask

  // The channel count shrinks below the current channel position.
  task automatic test_channel_shrink();
    configure(16'd4, 16'd8, 16'd3);
    repeat (4) send_sample(rand_sample(), 1'b0);
    configure(16'd4, 16'd2, 16'd3);
    send_sample(rand_sample(), 1'b0);
    send_sample(rand_sample(), 1'b0);
    send_sample(rand_sample(), 1'b1);
  endtask

  // last_frame on a channel that does not end the frame flushes without a restart.
  task automatic test_partial_frame();
    configure(16'd2, 16'd3, 16'd2);
    send_sample(24'sd100, 1'b0);
    send_sample(-24'sd100, 1'b1);
    send_sample(24'sd7, 1'b0);
    send_sample(-24'sd7, 1'b0);
  endtask

  // Levels cut off by a smaller level count keep their contents until reenabled.
  task automatic test_stale_levels();
    configure(16'd1, 16'd1, 16'd3);
    repeat (5) send_sample(rand_sample(), 1'b0);
    configure(16'd1, 16'd1, 16'd2);
    repeat (2) send_sample(rand_sample(), 1'b0);
    configure(16'd1, 16'd1, 16'd3);
    send_sample(rand_sample(), 1'b1);
  endtask

  task automatic test_random_buffers(input int target);
    logic [BASE_W-1:0] base;
    logic [NCH_W-1:0]  nch;
    logic [NLEV_W-1:0] nlev;
    while (items_sent < target) begin
      case ($urandom_range(0, 7))
        0:       base = 16'd1;
        1:       base = 16'hFFFF;
        2:       base = 16'd0;
        default: base = BASE_W'($urandom_range(1, 6));
      endcase
      nch  = ($urandom_range(0, 5) == 0) ? NCH_W'($urandom) : NCH_W'($urandom_range(1, 8));
      nlev = ($urandom_range(0, 5) == 0) ? NLEV_W'($urandom) : NLEV_W'($urandom_range(1, 8));
      // Upper data bits are don't-care for the count registers.
      configure(base, {12'($urandom), nch}, {12'($urandom), nlev});
      repeat ($urandom_range(1, 3)) send_buffer($urandom_range(1, 8), 1'b1);
    end
  endtask

  // The receiver holds off long enough for the block to stall its input,
  // then the sender waits for every result before going on.
  task automatic test_backpressure();
    configure(16'd1, 16'd2, 16'd3);
    hold_cycles = 150;
    send_buffer(15, 1'b0);
    wait_drained();
    send_buffer(5, 1'b0);
  endtask

  task automatic test_steady_stream();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    configure(16'd2, 16'd3, 16'd4);
    send_buffer(15, 1'b0);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    last_frame_i = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_BASE;
    cfg_data_i   = '0;
    fail_count   = 0;
    items_sent   = 0;
    hold_cycles  = 0;
    in_gaps      = 1'b1;
    out_gaps     = 1'b1;
    reset_pyramid();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_register_limits();
    test_channel_shrink();
    test_partial_frame();
    test_stale_levels();
    test_random_buffers(items_sent + 200);
    test_backpressure();
    test_steady_stream();
    wait_drained();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d peaks outstanding", expected_peaks.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
